// ===== rtl/core/pickle_coverage_line_parser_defines.svh =====
// Assertion macros shared by the pickle coverage line parser modules.
`ifndef PICKLE_COVERAGE_LINE_PARSER_DEFINES_SVH
`define PICKLE_COVERAGE_LINE_PARSER_DEFINES_SVH

// Implication checked in the same cycle, disabled while reset is asserted.
`define PCL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pcl assertion failed");

// Implication checked in the next cycle, disabled while reset is asserted.
`define PCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pcl assertion failed");

`endif

// ===== rtl/core/pcl_pkg.sv =====
// Package with opcode constants, codes and shared types of the pickle line parser.
package pcl_pkg;

  // Opcode bytes recognized by the parser.
  localparam logic [7:0] OpProto     = 8'h80;
  localparam logic [7:0] OpMemo      = 8'h71;  // 'q'
  localparam logic [7:0] OpBinString = 8'h55;  // 'U'
  localparam logic [7:0] OpBinInt1   = 8'h4b;  // 'K'
  localparam logic [7:0] OpBinInt2   = 8'h4d;  // 'M'
  localparam logic [7:0] OpStop      = 8'h2e;  // '.'
  localparam logic [7:0] OpEmptyDict = 8'h7d;  // '}'
  localparam logic [7:0] OpEmptyList = 8'h5d;  // ']'
  localparam logic [7:0] OpMark      = 8'h28;  // '('
  localparam logic [7:0] OpAppends   = 8'h65;  // 'e'
  localparam logic [7:0] OpSetItem   = 8'h73;  // 's'
  localparam logic [7:0] OpSetItems  = 8'h75;  // 'u'

  // Highest protocol version that is accepted.
  localparam logic [7:0] ProtoMax = 8'd2;

  // Default depth of the queue between front and back.
  localparam int unsigned QueueDepthDefault = 2;

  // Error codes reported with a result word.
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_PROTO  = 2'd1,
    ERR_OPCODE = 2'd2
  } err_e;

  // Parse phases, one-hot.
  typedef enum logic [8:0] {
    PH_OPCODE  = 9'b000000001,
    PH_PROTO   = 9'b000000010,
    PH_MEMO    = 9'b000000100,
    PH_STRLEN  = 9'b000001000,
    PH_STRSKIP = 9'b000010000,
    PH_INT1    = 9'b000100000,
    PH_INT2LO  = 9'b001000000,
    PH_INT2HI  = 9'b010000000,
    PH_HALTED  = 9'b100000000
  } phase_e;

  // Classified event handed from the front to the back, one per input word.
  typedef struct packed {
    logic        clear;        // stream start: drop the run history first
    logic        line_valid;
    logic [15:0] line_number;
    logic        done;
    err_e        error_code;
  } event_t;

endpackage

// ===== rtl/core/pcl_front.sv =====
// Front part: byte-level opcode parser that turns each input word into an event.
module pcl_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       data_byte_i,
  input  logic             stream_start_i,
  output pcl_pkg::event_t  event_o
);

  pcl_pkg::phase_e phase_q, phase_d, phase_cur;
  logic [7:0]      skip_q, skip_d;
  logic [7:0]      low_q, low_d;

  // A stream start restarts parsing at the opcode phase for this byte.
  assign phase_cur = stream_start_i ? pcl_pkg::PH_OPCODE : phase_q;

  // Phase transitions and event classification.
  always_comb begin
    phase_d               = phase_cur;
    skip_d                = skip_q;
    low_d                 = low_q;
    event_o.clear         = stream_start_i;
    event_o.line_valid    = 1'b0;
    event_o.line_number   = 16'd0;
    event_o.done          = 1'b0;
    event_o.error_code    = pcl_pkg::ERR_NONE;
    unique case (phase_cur)
      pcl_pkg::PH_OPCODE: begin
        unique case (data_byte_i)
          pcl_pkg::OpProto:     phase_d = pcl_pkg::PH_PROTO;
          pcl_pkg::OpMemo:      phase_d = pcl_pkg::PH_MEMO;
          pcl_pkg::OpBinString: phase_d = pcl_pkg::PH_STRLEN;
          pcl_pkg::OpBinInt1:   phase_d = pcl_pkg::PH_INT1;
          pcl_pkg::OpBinInt2:   phase_d = pcl_pkg::PH_INT2LO;
          pcl_pkg::OpEmptyDict, pcl_pkg::OpEmptyList, pcl_pkg::OpMark,
          pcl_pkg::OpAppends, pcl_pkg::OpSetItem, pcl_pkg::OpSetItems: begin
            phase_d = pcl_pkg::PH_OPCODE;
          end
          pcl_pkg::OpStop: begin
            event_o.done = 1'b1;
            phase_d      = pcl_pkg::PH_HALTED;
          end
          default: begin
            event_o.error_code = pcl_pkg::ERR_OPCODE;
            phase_d            = pcl_pkg::PH_HALTED;
          end
        endcase
      end
      pcl_pkg::PH_PROTO: begin
        if (data_byte_i > pcl_pkg::ProtoMax) begin
          event_o.error_code = pcl_pkg::ERR_PROTO;
          phase_d            = pcl_pkg::PH_HALTED;
        end else begin
          phase_d = pcl_pkg::PH_OPCODE;
        end
      end
      pcl_pkg::PH_MEMO: phase_d = pcl_pkg::PH_OPCODE;
      pcl_pkg::PH_STRLEN: begin
        skip_d  = data_byte_i;
        phase_d = (data_byte_i == 8'd0) ? pcl_pkg::PH_OPCODE : pcl_pkg::PH_STRSKIP;
      end
      pcl_pkg::PH_STRSKIP: begin
        skip_d = skip_q - 8'd1;
        if (skip_q == 8'd1) begin
          phase_d = pcl_pkg::PH_OPCODE;
        end
      end
      pcl_pkg::PH_INT1: begin
        event_o.line_valid  = 1'b1;
        event_o.line_number = {8'd0, data_byte_i};
        phase_d             = pcl_pkg::PH_OPCODE;
      end
      pcl_pkg::PH_INT2LO: begin
        low_d   = data_byte_i;
        phase_d = pcl_pkg::PH_INT2HI;
      end
      pcl_pkg::PH_INT2HI: begin
        event_o.line_valid  = 1'b1;
        event_o.line_number = {data_byte_i, low_q};
        phase_d             = pcl_pkg::PH_OPCODE;
      end
      default: phase_d = pcl_pkg::PH_HALTED;
    endcase
  end

  // Parser state advances only on an accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcl_pkg::PH_OPCODE;
      skip_q  <= 8'd0;
      low_q   <= 8'd0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      low_q   <= low_d;
    end
  end

endmodule

// ===== rtl/core/pcl_queue.sv =====
// Small register queue that decouples the parser front from the result back.
`include "pickle_coverage_line_parser_defines.svh"

module pcl_queue #(
  parameter int unsigned Depth = pcl_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcl_pkg::event_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output pcl_pkg::event_t data_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcl_pkg::event_t     entries_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Entry storage; written at the write pointer on a push.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `PCL_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o)
  `PCL_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, pop_i, !empty_o)

endmodule

// ===== rtl/core/pcl_back.sv =====
// Back part: run check against the previous line and the registered result word.
`include "pickle_coverage_line_parser_defines.svh"

module pcl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pcl_pkg::event_t event_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            line_valid_o,
  output logic [15:0]     line_number_o,
  output logic            starts_range_o,
  output logic            stream_done_o,
  output logic [1:0]      error_code_o
);

  logic            out_valid_q;
  logic            line_valid_q;
  logic [15:0]     line_number_q;
  logic            starts_q, starts_d;
  logic            done_q;
  pcl_pkg::err_e   err_q;
  logic [15:0]     prev_q;
  logic            have_q, have_cur;

  // Take the next event when the output register is free or being drained.
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  // A stream start drops the run history before this event is checked.
  assign have_cur = have_q && !event_i.clear;
  assign starts_d = event_i.line_valid &&
                    (!have_cur || ({1'b0, prev_q} + 17'd1 != {1'b0, event_i.line_number}));

  // Output valid and run history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q      <= 16'd0;
      have_q      <= 1'b0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        if (event_i.line_valid) begin
          prev_q <= event_i.line_number;
          have_q <= 1'b1;
        end else if (event_i.clear) begin
          prev_q <= 16'd0;
          have_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      line_valid_q  <= event_i.line_valid;
      line_number_q <= event_i.line_number;
      starts_q      <= starts_d;
      done_q        <= event_i.done;
      err_q         <= event_i.error_code;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_valid_o   = line_valid_q;
  assign line_number_o  = line_number_q;
  assign starts_range_o = starts_q;
  assign stream_done_o  = done_q;
  assign error_code_o   = err_q;

  `PCL_ASSERT_IMP(a_line_clean, clk_i, rst_ni, out_valid_q && line_valid_q, !done_q && (err_q == pcl_pkg::ERR_NONE))
  `PCL_ASSERT_NEXT(a_hist_set, clk_i, rst_ni, pop_o && event_i.line_valid, have_q && (prev_q == $past(event_i.line_number)))

endmodule

// ===== rtl/core/pickle_coverage_line_parser.sv =====
// Top level of the pickle coverage line parser: front parser, event queue and back.
// Each accepted word's event is registered in the queue and then in the back's result word.
// Throughput: one byte per cycle while the queue has room; the front decodes combinationally.
// The queue lets the input keep flowing for up to QueueDepth words while a result waits.
// Reset (rst_ni low, asynchronous) returns to the opcode phase and clears the run history.
module pickle_coverage_line_parser #(
  parameter int unsigned QueueDepth = pcl_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_valid_o,
  output logic [15:0] line_number_o,
  output logic        starts_range_o,
  output logic        stream_done_o,
  output logic [1:0]  error_code_o
);

  pcl_pkg::event_t front_event, queue_event;
  logic            accept, full, empty, pop;

  // A word is accepted whenever the queue has room.
  assign in_ready_o = !full;
  assign accept     = in_valid_i && !full;

  pcl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .stream_start_i (stream_start_i),
    .event_o        (front_event)
  );

  pcl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_event),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_event),
    .empty_o (empty)
  );

  pcl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .event_i        (queue_event),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_valid_o   (line_valid_o),
    .line_number_o  (line_number_o),
    .starts_range_o (starts_range_o),
    .stream_done_o  (stream_done_o),
    .error_code_o   (error_code_o)
  );

endmodule
